### sv/mhpq_pkg.sv
// Shared constants and types of the max-heap priority queue.
package mhpq_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast along the cell row
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

### sv/mhpq_if.sv
// Valid/ready channel interfaces for command and result words.
interface mhpq_in_if #(
    parameter int VW = 32
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic signed [VW-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mhpq_out_if #(
    parameter int VW = 32,
    parameter int CW = 11
);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] popped_value;
    logic signed [VW-1:0] top_value;
    logic [CW-1:0]        entry_count;
    logic                 empty_res;
    logic [1:0]           status;

    modport source (output valid, output popped_value, output top_value,
                    output entry_count, output empty_res, output status,
                    input ready);
    modport sink   (input valid, input popped_value, input top_value,
                    input entry_count, input empty_res, input status,
                    output ready);
endinterface

### sv/mhpq_cell.sv
// One storage cell of the sorted row: keeps, takes the new value, or shifts.
module mhpq_cell #(
    parameter int VW    = mhpq_pkg::VALUE_WIDTH_DEF,
    parameter int CW    = 11,
    parameter int INDEX = 0
) (
    input  logic                   i_clk,
    input  mhpq_pkg::t_cell_ctl    i_ctl,
    input  logic signed [VW-1:0]   i_value,
    input  logic [CW-1:0]          i_count,
    input  logic signed [VW-1:0]   i_prev,
    input  logic                   i_prev_ge,
    input  logic signed [VW-1:0]   i_next,
    output logic signed [VW-1:0]   o_value,
    output logic                   o_ge
);
    import mhpq_pkg::*;

    logic signed [VW-1:0] r_value;
    logic signed [VW-1:0] n_value;
    logic                 w_occ;

    assign w_occ   = i_count > CW'(INDEX);
    assign o_ge    = r_value >= i_value;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.push) begin
            if (!(w_occ && o_ge)) begin
                n_value = i_prev_ge ? i_value : i_prev;
            end
        end else if (i_ctl.pop) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

### sv/max_heap_priority_queue_unit.sv
// Max priority queue: a row of cells kept in descending order.
//
// Channels: i_in carries a command word (mode 0 pushes value, mode 1 pops
// the maximum); o_out carries one result word per command with the popped
// value, the new maximum, the entry count, an empty flag and a status
// (ok, push refused because full, pop refused because empty).
// Every cell compares its entry with the pushed value in parallel and either
// keeps it, takes the new value or takes its upper neighbour's entry; a pop
// shifts the whole row up by one. The result word appears the cycle after
// acceptance, and a new command is accepted every cycle while the result
// register is free or being emptied. When the receiver stalls, the result is
// held and i_in.ready drops until it is taken. Reset empties the queue and
// clears the result valid flag; the cell contents are not cleared, entries
// beyond the count are never shown.
module max_heap_priority_queue_unit #(
    parameter int DEPTH       = mhpq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF,
    parameter int CW          = $clog2(DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhpq_in_if.sink    i_in,
    mhpq_out_if.source o_out
);
    import mhpq_pkg::*;

    localparam int VW = VALUE_WIDTH;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    logic signed [VW-1:0] r_popped;
    logic signed [VW-1:0] r_top;
    logic [CW-1:0]        r_out_count;
    t_status              r_status;

    logic signed [VW-1:0] n_popped;
    logic signed [VW-1:0] n_top;
    t_status              n_status;

    logic                 w_fire;
    logic                 w_full;
    logic                 w_empty;
    t_cell_ctl            w_ctl;
    logic signed [VW-1:0] w_val [DEPTH];
    logic                 w_ge  [DEPTH];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_full     = r_count == CW'(DEPTH);
    assign w_empty    = r_count == '0;
    assign w_ctl.push = w_fire && (i_in.mode == MODE_PUSH) && !w_full;
    assign w_ctl.pop  = w_fire && (i_in.mode == MODE_POP) && !w_empty;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VW-1:0] w_prev;
        logic                 w_prev_ge;
        logic signed [VW-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev    = i_in.value;
            assign w_prev_ge = 1'b1;
        end else begin : g_mid
            assign w_prev    = w_val[g-1];
            assign w_prev_ge = w_ge[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_val[g];
        end else begin : g_inner
            assign w_next = w_val[g+1];
        end
        mhpq_cell #(
            .VW    (VW),
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_value   (i_in.value),
            .i_count   (r_count),
            .i_prev    (w_prev),
            .i_prev_ge (w_prev_ge),
            .i_next    (w_next),
            .o_value   (w_val[g]),
            .o_ge      (w_ge[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_popped = '0;
        n_status = ST_OK;
        n_top    = w_empty ? '0 : w_val[0];
        if (i_in.mode == MODE_PUSH) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
                if (w_empty || !w_ge[0]) begin
                    n_top = i_in.value;
                end
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count  = r_count - CW'(1);
                n_popped = w_val[0];
                n_top    = (r_count == CW'(1)) ? '0 : w_val[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_popped    <= n_popped;
            r_top       <= n_top;
            r_out_count <= n_count;
            r_status    <= n_status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_popped;
    assign o_out.top_value    = r_top;
    assign o_out.entry_count  = r_out_count;
    assign o_out.empty_res    = r_out_count == '0;
    assign o_out.status       = r_status;

endmodule

### sv/mhpq_checker.sv
// Port-level assertions for the max-heap priority queue, bound to the top.
module mhpq_checker #(
    parameter int VW = mhpq_pkg::VALUE_WIDTH_DEF,
    parameter int CW = 11
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic signed [VW-1:0] i_top_value,
    input logic [CW-1:0]        i_entry_count,
    input logic                 i_empty_res,
    input logic [1:0]           i_status
);
    import mhpq_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted word gave no result next cycle");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_entry_count)
            && $stable(i_top_value) && $stable(i_status))
        else $error("stalled result changed");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_empty_res == (i_entry_count == '0))
            && (!i_empty_res || i_top_value == '0))
        else $error("empty flag, count and top disagree");

endmodule

bind max_heap_priority_queue_unit mhpq_checker #(
    .VW (VALUE_WIDTH),
    .CW (CW)
) u_mhpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_top_value   (o_out.top_value),
    .i_entry_count (o_out.entry_count),
    .i_empty_res   (o_out.empty_res),
    .i_status      (o_out.status)
);

### test/max_heap_priority_queue_unit_tb.sv
// Testbench: directed table, random mix, fill, churn; checked against a heap predictor.
module max_heap_priority_queue_unit_tb;
    import mhpq_pkg::*;

    localparam int VW    = VALUE_WIDTH_DEF;
    localparam int CW    = $clog2(DEPTH_DEF + 1);
    localparam int N_DIR = 25;

    typedef struct packed {
        logic signed [VW-1:0] popped;
        logic signed [VW-1:0] top;
        logic [CW-1:0]        count;
        logic                 empty;
        t_status              status;
    } t_report;

    typedef struct packed {
        logic          mode;
        logic [VW-1:0] value;
        logic          typed;
        t_report       rep;
    } t_step;

    localparam t_report NO_REPORT = '{32'h0, 32'h0, 11'd0, 1'b0, ST_OK};

    localparam t_step DIR_STEPS [N_DIR] = '{
        '{MODE_POP,  32'h0000_0000, 1'b1, '{32'h0, 32'h0, 11'd0, 1'b1, ST_EMPTY}},
        '{MODE_PUSH, 32'h7fff_ffff, 1'b1, '{32'h0, 32'h7fff_ffff, 11'd1, 1'b0, ST_OK}},
        '{MODE_PUSH, 32'h8000_0000, 1'b1, '{32'h0, 32'h7fff_ffff, 11'd2, 1'b0, ST_OK}},
        '{MODE_PUSH, 32'h0000_0000, 1'b0, NO_REPORT},
        '{MODE_PUSH, 32'hffff_ffff, 1'b0, NO_REPORT},
        '{MODE_PUSH, 32'h0000_0005, 1'b0, NO_REPORT},
        '{MODE_PUSH, 32'h0000_0005, 1'b0, NO_REPORT},
        '{MODE_PUSH, 32'h0000_0005, 1'b0, NO_REPORT},
        '{MODE_PUSH, 32'h8000_0001, 1'b0, NO_REPORT},
        '{MODE_POP,  32'hdead_beef, 1'b1, '{32'h7fff_ffff, 32'h5, 11'd7, 1'b0, ST_OK}},
        '{MODE_POP,  32'h0000_0000, 1'b0, NO_REPORT},
        '{MODE_POP,  32'hffff_ffff, 1'b0, NO_REPORT},
        '{MODE_POP,  32'h0000_0000, 1'b0, NO_REPORT},
        '{MODE_POP,  32'h0000_0000, 1'b0, NO_REPORT},
        '{MODE_POP,  32'h0000_0000, 1'b0, NO_REPORT},
        '{MODE_POP,  32'h0000_0000, 1'b0, NO_REPORT},
        '{MODE_POP,  32'h0000_0000, 1'b0, NO_REPORT},
        '{MODE_POP,  32'h0000_0000, 1'b1, '{32'h0, 32'h0, 11'd0, 1'b1, ST_EMPTY}},
        '{MODE_PUSH, 32'h0000_0001, 1'b0, NO_REPORT},
        '{MODE_PUSH, 32'h0000_0001, 1'b0, NO_REPORT},
        '{MODE_PUSH, 32'h0000_0002, 1'b0, NO_REPORT},
        '{MODE_PUSH, 32'h0000_0001, 1'b0, NO_REPORT},
        '{MODE_POP,  32'h0000_0000, 1'b0, NO_REPORT},
        '{MODE_POP,  32'h0000_0000, 1'b0, NO_REPORT},
        '{MODE_POP,  32'h0000_0000, 1'b0, NO_REPORT}
    };

    logic i_clk;
    logic i_rst_n;

    mhpq_in_if  #(.VW(VW))           in_ch ();
    mhpq_out_if #(.VW(VW), .CW(CW))  out_ch ();

    max_heap_priority_queue_unit #(
        .DEPTH       (DEPTH_DEF),
        .VALUE_WIDTH (VW)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic signed [VW-1:0] pq_store [DEPTH_DEF];
    int unsigned          pq_count;
    t_report              reports_due [$];
    int unsigned          fail_cnt;
    bit                   tx_calm;
    bit                   rx_calm;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2, 3:    return $signed($urandom_range(0, 15)) - 8;
            default: return $signed($urandom);
        endcase
    endfunction

    // applies one word to the predicted heap, returns the result it should give
    function automatic t_report pq_execute(logic mode, logic signed [VW-1:0] value);
        t_report              rep;
        int unsigned          i;
        int unsigned          p;
        int unsigned          c;
        logic signed [VW-1:0] tmp;
        rep = NO_REPORT;
        if (mode == MODE_PUSH) begin
            if (pq_count >= DEPTH_DEF) begin
                rep.status = ST_FULL;
            end else begin
                i = pq_count;
                pq_store[i] = value;
                while (i > 0) begin
                    p = (i - 1) / 2;
                    if (!(pq_store[i] > pq_store[p])) break;
                    tmp = pq_store[i];
                    pq_store[i] = pq_store[p];
                    pq_store[p] = tmp;
                    i = p;
                end
                pq_count++;
            end
        end else begin
            if (pq_count == 0) begin
                rep.status = ST_EMPTY;
            end else begin
                rep.popped = pq_store[0];
                pq_count--;
                pq_store[0] = pq_store[pq_count];
                i = 0;
                while (2 * i + 1 < pq_count) begin
                    c = 2 * i + 1;
                    // right child wins a tie
                    if (c + 1 < pq_count && !(pq_store[c] > pq_store[c + 1])) c = c + 1;
                    if (!(pq_store[c] > pq_store[i])) break;
                    tmp = pq_store[c];
                    pq_store[c] = pq_store[i];
                    pq_store[i] = tmp;
                    i = c;
                end
            end
        end
        rep.top   = (pq_count > 0) ? pq_store[0] : '0;
        rep.count = CW'(pq_count);
        rep.empty = (pq_count == 0);
        return rep;
    endfunction

    task automatic send_word(input logic mode, input logic signed [VW-1:0] value,
                             input logic typed, input t_report typed_rep);
        int unsigned gap;
        t_report     rep;
        gap = draw_wait(tx_calm);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= mode;
        in_ch.value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        rep = pq_execute(mode, value);
        reports_due.push_back(typed ? typed_rep : rep);
    endtask

    // result side
    initial begin
        int unsigned gap;
        t_report     got;
        t_report     want;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = draw_wait(rx_calm);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got = '{out_ch.popped_value, out_ch.top_value, out_ch.entry_count,
                    out_ch.empty_res, t_status'(out_ch.status)};
            if (reports_due.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("unexpected result word: popped %0d top %0d count %0d",
                             got.popped, got.top, got.count);
                end
            end else begin
                want = reports_due.pop_front();
                if (got.popped !== want.popped || got.top !== want.top ||
                    got.count !== want.count || got.empty !== want.empty ||
                    got.status !== want.status) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("mismatch: exp popped %0d top %0d count %0d empty %0b st %0d",
                                 want.popped, want.top, want.count, want.empty, want.status);
                        $display("          got popped %0d top %0d count %0d empty %0b st %0d",
                                 got.popped, got.top, got.count, got.empty, got.status);
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.mode  <= MODE_PUSH;
        in_ch.value <= '0;
        pq_count    = 0;
        fail_cnt    = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_DIR; n++) begin
            send_word(DIR_STEPS[n].mode, DIR_STEPS[n].value, DIR_STEPS[n].typed,
                      DIR_STEPS[n].rep);
        end

        // mixed traffic around a shallow heap, empty pops included
        for (int n = 0; n < 300; n++) begin
            send_word(($urandom_range(0, 99) < 55) ? MODE_PUSH : MODE_POP, pick_value(),
                      1'b0, NO_REPORT);
        end

        // fill to the top, then push into a full heap
        while (pq_count < DEPTH_DEF) begin
            send_word(($urandom_range(0, 19) == 0) ? MODE_POP : MODE_PUSH, pick_value(),
                      1'b0, NO_REPORT);
        end
        repeat (6) send_word(MODE_PUSH, pick_value(), 1'b0, NO_REPORT);

        // churn on a deep heap
        for (int n = 0; n < 300; n++) begin
            send_word($urandom_range(0, 1) ? MODE_PUSH : MODE_POP, pick_value(),
                      1'b0, NO_REPORT);
        end

        in_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("max_heap_priority_queue_unit_tb: done, clean");
        end else begin
            $display("max_heap_priority_queue_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("max_heap_priority_queue_unit_tb: done, errors");
        $finish;
    end

endmodule
